FILE: hw/rtl/uniqueness_hash_table_top_assert.svh
// assertion macros for the hash table
`ifndef UNIQUENESS_HASH_TABLE_TOP_ASSERT_SVH
`define UNIQUENESS_HASH_TABLE_TOP_ASSERT_SVH
`define UHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define UHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: hw/rtl/uht_pkg.sv
package uht_pkg;
   localparam int TableDepth = 64;
   localparam int IdxBits = $clog2(TableDepth);
   localparam int SizeBits = IdxBits + 1;
   localparam int VertexBits = 16;
   localparam int GenBits = 16;
   localparam int CountBits = 16;
   localparam int SizeLimit = 2 * TableDepth / 3 - 1;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_MATCH = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_STARTED = 4'd0,
      ST_INSERTED = 4'd1,
      ST_DUPLICATE = 4'd2,
      ST_FULL = 4'd3,
      ST_UNIQUE = 4'd4,
      ST_NOT_UNIQUE = 4'd5,
      ST_ABSENT = 4'd6,
      ST_PROBE_ERROR = 4'd7,
      ST_UNUSED = 4'd8,
      ST_NONE = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CLEAR,
      FSM_MOD,
      FSM_READ,
      FSM_CHECK,
      FSM_SCAN,
      FSM_SCAN_CHECK,
      FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic [GenBits-1:0] gen;
      logic [31:0] key;
      logic [VertexBits-1:0] vertex;
      logic [CountBits-1:0] count;
      logic used;
   } entry_type;
endpackage

FILE: hw/rtl/uniqueness_hash_table_top.sv
// start answers once the active size is set; on the first start or a generation wrap it first
// clears the table one slot per cycle. insert/match reduce the key modulo the active size
// (four key bits per cycle), then probe slot by slot with one table read each.
// finish: scans every slot of the active size, and stalls while a waiting result is not taken.
// one request at a time; ready returns once the last result is taken.
// synchronous reset clears control, generation and size; the table is cleared by the first start.
module uniqueness_hash_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], neighbor_count[13:2], key_value[45:14], device_class[77:46],
   // vertex_id[93:78], zero fill
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[3:0], found_vertex[19:4], zero fill
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);
`include "uniqueness_hash_table_top_assert.svh"

   localparam int IB = uht_pkg::IdxBits;
   localparam int SB = uht_pkg::SizeBits;

   uht_pkg::entry_type mem [uht_pkg::TableDepth];
   uht_pkg::entry_type rd_ff;
   uht_pkg::entry_type wr_data;
   logic wr_en;
   logic [IB-1:0] wr_addr, rd_addr;

   uht_pkg::fsm_type state_ff, state_in;
   uht_pkg::action_type act_ff;
   logic [31:0] key_ff, key_in;
   logic [uht_pkg::VertexBits-1:0] vid_ff;
   logic [11:0] ncount_ff;
   logic [uht_pkg::GenBits-1:0] gen_ff, gen_in;
   logic [SB-1:0] size_ff, size_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [SB-1:0] cnt_ff, cnt_in;
   logic [2:0] step_ff, step_in;
   logic [SB-1:0] rem_ff, rem_in, rem_next;
   logic [SB:0] part;
   logic found_ff, found_in;
   logic rv_ff;
   logic [3:0] rs_ff;
   logic [uht_pkg::VertexBits-1:0] rvx_ff;
   logic rl_ff;
   logic emit;
   logic [3:0] es;
   logic [uht_pkg::VertexBits-1:0] ev;
   logic el;
   logic live;
   logic [12:0] size_calc;
   logic out_load;
   logic [3:0] out_status;
   logic [uht_pkg::VertexBits-1:0] out_vertex;
   logic out_last;

   // original key kept for compares; key_ff is consumed by the modulo
   logic [31:0] key_full, key_full_ff;
   assign key_full = key_full_ff;

   // pending unused result held back until the next is known
   logic pend_ff;
   logic [uht_pkg::VertexBits-1:0] pv_ff;

   assign req_tready = (state_ff == uht_pkg::FSM_IDLE) && !rv_ff;
   wire req_fire = req_tvalid && req_tready;
   wire rsp_fire = rv_ff && rsp_tready;
   wire busy_out = rv_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign live = (gen_ff != '0) && (rd_ff.gen == gen_ff);
   assign size_calc = 13'(ncount_ff) + 13'(ncount_ff >> 1) + 13'd1;

   // restoring remainder, four key bits per cycle, msb first
   always_comb begin
      rem_next = rem_ff;
      part = '0;
      for (int b = 0; b < 4; b++) begin
         part = {rem_next, key_ff[31 - b]};
         if (part >= {1'b0, size_ff}) part = part - {1'b0, size_ff};
         rem_next = part[SB-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      key_in = key_ff;
      gen_in = gen_ff;
      size_in = size_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      found_in = found_ff;
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      emit = 1'b0;
      es = uht_pkg::ST_NONE;
      ev = '0;
      el = 1'b1;
      case (state_ff)
         uht_pkg::FSM_IDLE: begin
            if (req_fire) begin
               key_in = req_tdata[45:14] + req_tdata[77:46];
               idx_in = '0;
               cnt_in = '0;
               step_in = '0;
               rem_in = '0;
               found_in = 1'b0;
               state_in = uht_pkg::FSM_MOD;
            end
         end
         uht_pkg::FSM_MOD: begin
            case (act_ff)
               uht_pkg::ACT_START: begin
                  if (ncount_ff < 12'(uht_pkg::SizeLimit) &&
                      size_calc <= 13'(uht_pkg::TableDepth))
                     size_in = SB'(size_calc);
                  else
                     size_in = SB'(uht_pkg::TableDepth);
                  if (gen_ff == '0 || gen_ff == '1) begin
                     idx_in = '0;
                     state_in = uht_pkg::FSM_CLEAR;
                  end else begin
                     gen_in = gen_ff + 1'b1;
                     emit = 1'b1;
                     es = uht_pkg::ST_STARTED;
                     state_in = uht_pkg::FSM_IDLE;
                  end
               end
               uht_pkg::ACT_FINISH: begin
                  if (size_ff == '0) begin
                     emit = 1'b1;
                     state_in = uht_pkg::FSM_IDLE;
                  end else begin
                     rd_addr = '0;
                     state_in = uht_pkg::FSM_SCAN;
                  end
               end
               default: begin
                  if (size_ff == '0) begin
                     emit = 1'b1;
                     es = (act_ff == uht_pkg::ACT_INSERT) ? uht_pkg::ST_FULL
                                                          : uht_pkg::ST_PROBE_ERROR;
                     state_in = uht_pkg::FSM_IDLE;
                  end else begin
                     rem_in = rem_next;
                     key_in = {key_ff[27:0], 4'd0};
                     step_in = step_ff + 1'b1;
                     if (step_ff == 3'd7) begin
                        idx_in = IB'(rem_next);
                        state_in = uht_pkg::FSM_READ;
                     end
                  end
               end
            endcase
         end
         uht_pkg::FSM_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IB'(uht_pkg::TableDepth - 1)) begin
               gen_in = 16'd1;
               emit = 1'b1;
               es = uht_pkg::ST_STARTED;
               state_in = uht_pkg::FSM_IDLE;
            end
         end
         uht_pkg::FSM_READ: begin
            rd_addr = idx_ff;
            state_in = uht_pkg::FSM_CHECK;
         end
         uht_pkg::FSM_CHECK: begin
            emit = 1'b1;
            state_in = uht_pkg::FSM_IDLE;
            if (!live) begin
               if (act_ff == uht_pkg::ACT_INSERT) begin
                  wr_en = 1'b1;
                  wr_data.gen = gen_ff;
                  wr_data.key = key_full;
                  wr_data.vertex = vid_ff;
                  wr_data.count = 16'd1;
                  wr_data.used = 1'b0;
                  es = uht_pkg::ST_INSERTED;
               end else es = uht_pkg::ST_ABSENT;
            end else if (rd_ff.key == key_full) begin
               if (act_ff == uht_pkg::ACT_INSERT) begin
                  wr_en = 1'b1;
                  if (rd_ff.count != '1) wr_data.count = rd_ff.count + 1'b1;
                  wr_data.used = 1'b1;
                  es = uht_pkg::ST_DUPLICATE;
               end else if (rd_ff.used) begin
                  es = uht_pkg::ST_NOT_UNIQUE;
               end else begin
                  wr_en = 1'b1;
                  wr_data.used = 1'b1;
                  if (rd_ff.count == 16'd1) begin
                     es = uht_pkg::ST_UNIQUE;
                     ev = rd_ff.vertex;
                  end else es = uht_pkg::ST_NOT_UNIQUE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
               idx_in = (SB'(idx_ff) + 1'b1 >= size_ff) ? '0 : idx_ff + 1'b1;
               if (cnt_in == size_ff) begin
                  es = (act_ff == uht_pkg::ACT_INSERT) ? uht_pkg::ST_FULL
                                                       : uht_pkg::ST_PROBE_ERROR;
               end else begin
                  emit = 1'b0;
                  state_in = uht_pkg::FSM_READ;
               end
            end
         end
         uht_pkg::FSM_SCAN: begin
            rd_addr = idx_ff;
            if (!busy_out) state_in = uht_pkg::FSM_SCAN_CHECK;
         end
         uht_pkg::FSM_SCAN_CHECK: begin
            // hold each unused entry back until the next is found, so last can mark the final one
            if (live && !rd_ff.used) begin
               emit = 1'b1;
               es = uht_pkg::ST_UNUSED;
               ev = rd_ff.vertex;
               el = 1'b0;
               found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (SB'(idx_ff) + 1'b1 >= size_ff) state_in = uht_pkg::FSM_OUT;
            else state_in = uht_pkg::FSM_SCAN;
         end
         uht_pkg::FSM_OUT: begin
            if (!busy_out) begin
               state_in = uht_pkg::FSM_IDLE;
               emit = !found_ff;
            end
         end
         default: state_in = uht_pkg::FSM_IDLE;
      endcase
   end

   // result register load; during a scan the held-back entry goes out first
   always_comb begin
      out_load = 1'b0;
      out_status = es;
      out_vertex = ev;
      out_last = el;
      if (state_ff == uht_pkg::FSM_SCAN_CHECK) begin
         if (emit && pend_ff) begin
            out_load = 1'b1;
            out_status = uht_pkg::ST_UNUSED;
            out_vertex = pv_ff;
            out_last = 1'b0;
         end
      end else if (state_ff == uht_pkg::FSM_OUT) begin
         if (!busy_out) begin
            out_load = 1'b1;
            out_last = 1'b1;
            if (pend_ff) begin
               out_status = uht_pkg::ST_UNUSED;
               out_vertex = pv_ff;
            end else begin
               out_status = uht_pkg::ST_NONE;
               out_vertex = '0;
            end
         end
      end else begin
         out_load = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= uht_pkg::action_type'(req_tdata[1:0]);
         ncount_ff <= req_tdata[13:2];
         vid_ff <= req_tdata[93:78];
         key_full_ff <= req_tdata[45:14] + req_tdata[77:46];
      end
      key_ff <= key_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff <= uht_pkg::FSM_IDLE;
         gen_ff <= '0;
         size_ff <= '0;
         found_ff <= 1'b0;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gen_ff <= gen_in;
         size_ff <= size_in;
         found_ff <= found_in;
         if (out_load) begin
            rv_ff <= 1'b1;
            rs_ff <= out_status;
            rvx_ff <= out_vertex;
            rl_ff <= out_last;
         end else if (rsp_fire) begin
            rv_ff <= 1'b0;
         end
         if (state_ff == uht_pkg::FSM_SCAN_CHECK && emit) begin
            pend_ff <= 1'b1;
            pv_ff <= ev;
         end else if (state_ff == uht_pkg::FSM_OUT && !busy_out) begin
            pend_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {4'd0, rvx_ff, rs_ff};
   assign rsp_tlast = rl_ff;

   `UHT_ASSERT_IMPL(a_idle_ready, clock, reset, req_tready, state_ff == uht_pkg::FSM_IDLE,
      "ready outside idle")
   `UHT_ASSERT_NEXT(a_live_gen, clock, reset, state_ff == uht_pkg::FSM_CLEAR &&
      state_in == uht_pkg::FSM_IDLE, gen_ff == 16'd1, "generation not restarted")
   `UHT_ASSERT_IMPL(a_size_range, clock, reset, 1'b1,
      size_ff <= SB'(uht_pkg::TableDepth), "active size out of range")
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      uht_pkg::status_type status;
      logic [15:0] vertex;
      logic last;
   } answer_type;

   typedef struct {
      uht_pkg::action_type act;
      logic [11:0] count;
      logic [31:0] kval;
      logic [31:0] kclass;
      logic [15:0] vid;
      bit typed;
      uht_pkg::status_type status;
      logic [15:0] vertex;
   } table_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [95:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;

   uniqueness_hash_table_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // shadow copy of the table
   logic [31:0] shadow_key [uht_pkg::TableDepth];
   logic [15:0] shadow_vertex [uht_pkg::TableDepth];
   logic [15:0] shadow_count [uht_pkg::TableDepth];
   logic shadow_used [uht_pkg::TableDepth];
   logic [15:0] shadow_gen [uht_pkg::TableDepth];
   logic [15:0] shadow_cur_gen;
   int shadow_size;

   answer_type answer_q [$];
   int errors;
   int requests;
   int answers;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout with %0d answers outstanding", answer_q.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit slot_live(int s);
      return shadow_cur_gen != 16'd0 && shadow_gen[s] == shadow_cur_gen;
   endfunction

   function automatic void push_answer(uht_pkg::status_type st, logic [15:0] v, logic l);
      answer_type a;
      a.status = st;
      a.vertex = v;
      a.last = l;
      answer_q.push_back(a);
   endfunction

   // works out the answers to one request and updates the shadow table
   function automatic void predict_table(uht_pkg::action_type act, logic [11:0] n,
                                         logic [31:0] key, logic [15:0] vid);
      int i;
      int s;
      int found;
      int k;
      answer_type a;
      if (act == uht_pkg::ACT_START) begin
         shadow_size = (n < uht_pkg::SizeLimit) ? 3 * n / 2 + 1 : uht_pkg::TableDepth;
         if (shadow_size > uht_pkg::TableDepth) shadow_size = uht_pkg::TableDepth;
         if (shadow_cur_gen == 16'd0) foreach (shadow_gen[j]) shadow_gen[j] = 16'd0;
         shadow_cur_gen = shadow_cur_gen + 16'd1;
         if (shadow_cur_gen == 16'd0) begin
            foreach (shadow_gen[j]) shadow_gen[j] = 16'd0;
            shadow_cur_gen = 16'd1;
         end
         push_answer(uht_pkg::ST_STARTED, 16'd0, 1'b1);
         return;
      end
      if (act == uht_pkg::ACT_FINISH) begin
         found = 0;
         for (k = 0; k < shadow_size; k++) begin
            if (slot_live(k) && !shadow_used[k]) begin
               push_answer(uht_pkg::ST_UNUSED, shadow_vertex[k], 1'b0);
               found++;
            end
         end
         if (found == 0) push_answer(uht_pkg::ST_NONE, 16'd0, 1'b1);
         else begin
            a = answer_q.pop_back();
            a.last = 1'b1;
            answer_q.push_back(a);
         end
         return;
      end
      if (shadow_size == 0) begin
         push_answer(act == uht_pkg::ACT_INSERT ? uht_pkg::ST_FULL : uht_pkg::ST_PROBE_ERROR,
                     16'd0, 1'b1);
         return;
      end
      i = key % shadow_size;
      for (k = 0; k < shadow_size; k++) begin
         s = i;
         if (!slot_live(s)) begin
            if (act == uht_pkg::ACT_INSERT) begin
               shadow_key[s] = key;
               shadow_vertex[s] = vid;
               shadow_count[s] = 16'd1;
               shadow_used[s] = 1'b0;
               shadow_gen[s] = shadow_cur_gen;
               push_answer(uht_pkg::ST_INSERTED, 16'd0, 1'b1);
            end else push_answer(uht_pkg::ST_ABSENT, 16'd0, 1'b1);
            return;
         end
         if (shadow_key[s] == key) begin
            if (act == uht_pkg::ACT_INSERT) begin
               if (shadow_count[s] != 16'hffff) shadow_count[s]++;
               shadow_used[s] = 1'b1;
               push_answer(uht_pkg::ST_DUPLICATE, 16'd0, 1'b1);
            end else if (shadow_used[s]) push_answer(uht_pkg::ST_NOT_UNIQUE, 16'd0, 1'b1);
            else begin
               shadow_used[s] = 1'b1;
               if (shadow_count[s] == 16'd1)
                  push_answer(uht_pkg::ST_UNIQUE, shadow_vertex[s], 1'b1);
               else push_answer(uht_pkg::ST_NOT_UNIQUE, 16'd0, 1'b1);
            end
            return;
         end
         i = (i + 1 >= shadow_size) ? 0 : i + 1;
      end
      push_answer(act == uht_pkg::ACT_INSERT ? uht_pkg::ST_FULL : uht_pkg::ST_PROBE_ERROR,
                  16'd0, 1'b1);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on answer %0d: %s got %0d, expected %0d", answers, what, got, want);
      errors++;
   endtask

   // drives one request and predicts once it is taken
   task automatic send_request(table_row_type r);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tdata = {2'b00, r.vid, r.kclass, r.kval, r.count, r.act};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (r.typed) begin
         predict_table(r.act, r.count, r.kval + r.kclass, r.vid);
         void'(answer_q.pop_back());
         push_answer(r.status, r.vertex, 1'b1);
      end else predict_table(r.act, r.count, r.kval + r.kclass, r.vid);
      requests++;
      @(negedge clock);
   endtask

   task automatic send_plain(uht_pkg::action_type act, logic [11:0] n, logic [31:0] key,
                             logic [15:0] vid);
      table_row_type r;
      r.act = act;
      r.count = n;
      r.kval = $urandom();
      r.kclass = key - r.kval;
      r.vid = vid;
      r.typed = 1'b0;
      r.status = uht_pkg::ST_NONE;
      r.vertex = 16'd0;
      send_request(r);
   endtask

   task automatic drain_answers();
      req_tvalid = 1'b0;
      while (answer_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            report_mismatch("status with none outstanding", rsp_tdata[3:0], -1);
         end else begin
            a = answer_q.pop_front();
            if (rsp_tdata[3:0] !== a.status) report_mismatch("status", rsp_tdata[3:0], a.status);
            if (rsp_tdata[19:4] !== a.vertex) report_mismatch("vertex", rsp_tdata[19:4], a.vertex);
            if (rsp_tlast !== a.last) report_mismatch("last", rsp_tlast, a.last);
         end
         answers++;
      end
   end

   // one round: start, inserts with repeats, matches mixed with random requests, finish
   task automatic run_round();
      logic [31:0] pool [8];
      logic [11:0] n;
      int m;
      int base_mod;
      n = ($urandom_range(9) == 0) ? 12'($urandom()) : 12'($urandom_range(12));
      send_plain(uht_pkg::ACT_START, n, 32'd0, 16'($urandom()));
      base_mod = shadow_size;
      foreach (pool[j]) begin
         // half the keys collide on the same home slot
         pool[j] = ($urandom_range(1)) ? 32'($urandom_range(3) * base_mod + 7) : $urandom();
      end
      m = $urandom_range(2, 8);
      repeat (m) send_plain(uht_pkg::ACT_INSERT, 12'($urandom()), pool[$urandom_range(7)],
                            16'($urandom()));
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(5) == 0)
            send_plain(uht_pkg::action_type'($urandom_range(3)), 12'($urandom()),
                       $urandom(), 16'($urandom()));
         else send_plain(uht_pkg::ACT_MATCH, 12'($urandom()), pool[$urandom_range(7)],
                         16'($urandom()));
      end
      send_plain(uht_pkg::ACT_FINISH, 12'($urandom()), $urandom(), 16'($urandom()));
   endtask

   table_row_type directed [$];

   function automatic table_row_type row(uht_pkg::action_type act, logic [11:0] n,
                                         logic [31:0] kv, logic [31:0] kc, logic [15:0] vid,
                                         bit typed, uht_pkg::status_type st,
                                         logic [15:0] v);
      table_row_type r;
      r.act = act;
      r.count = n;
      r.kval = kv;
      r.kclass = kc;
      r.vid = vid;
      r.typed = typed;
      r.status = st;
      r.vertex = v;
      return r;
   endfunction

   initial begin
      int phase;
      errors = 0;
      requests = 0;
      answers = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      shadow_cur_gen = 16'd0;
      shadow_size = 0;
      foreach (shadow_gen[j]) shadow_gen[j] = 16'd0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // before any start, then a one-slot table, then the full table
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd1, 32'd2, 16'd3, 1,
                             uht_pkg::ST_FULL, 16'd0));
      directed.push_back(row(uht_pkg::ACT_MATCH, 12'd0, 32'd1, 32'd2, 16'd3, 1,
                             uht_pkg::ST_PROBE_ERROR, 16'd0));
      directed.push_back(row(uht_pkg::ACT_FINISH, 12'hfff, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_NONE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_START, 12'd0, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_STARTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd10, 32'd0, 16'd5, 1,
                             uht_pkg::ST_INSERTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd11, 32'd0, 16'd6, 1,
                             uht_pkg::ST_FULL, 16'd0));
      directed.push_back(row(uht_pkg::ACT_MATCH, 12'd0, 32'd11, 32'd0, 16'd6, 1,
                             uht_pkg::ST_PROBE_ERROR, 16'd0));
      directed.push_back(row(uht_pkg::ACT_FINISH, 12'd0, 32'd0, 32'd0, 16'd0, 0,
                             uht_pkg::ST_NONE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd4, 32'd6, 16'd0, 1,
                             uht_pkg::ST_DUPLICATE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_MATCH, 12'd0, 32'd10, 32'd0, 16'd0, 1,
                             uht_pkg::ST_NOT_UNIQUE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_FINISH, 12'd0, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_NONE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_START, 12'hfff, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_STARTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'hffffffff, 32'd1, 16'hffff, 1,
                             uht_pkg::ST_INSERTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd64, 32'd0, 16'h1234, 1,
                             uht_pkg::ST_INSERTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_MATCH, 12'd0, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_UNIQUE, 16'hffff));
      directed.push_back(row(uht_pkg::ACT_MATCH, 12'd0, 32'hffffffff, 32'hffffffff, 16'd0, 1,
                             uht_pkg::ST_ABSENT, 16'd0));
      directed.push_back(row(uht_pkg::ACT_MATCH, 12'd0, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_NOT_UNIQUE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_FINISH, 12'd0, 32'd0, 32'd0, 16'd0, 0,
                             uht_pkg::ST_NONE, 16'd0));
      // size just below and at the cap threshold
      directed.push_back(row(uht_pkg::ACT_START, 12'(uht_pkg::SizeLimit - 1), 32'd0, 32'd0,
                             16'd0, 1, uht_pkg::ST_STARTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd60, 32'd0, 16'h0f0f, 0,
                             uht_pkg::ST_NONE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_INSERT, 12'd0, 32'd121, 32'd0, 16'hf0f0, 0,
                             uht_pkg::ST_NONE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_FINISH, 12'd0, 32'd0, 32'd0, 16'd0, 0,
                             uht_pkg::ST_NONE, 16'd0));
      directed.push_back(row(uht_pkg::ACT_START, 12'(uht_pkg::SizeLimit), 32'd0, 32'd0,
                             16'd0, 1, uht_pkg::ST_STARTED, 16'd0));
      directed.push_back(row(uht_pkg::ACT_FINISH, 12'd0, 32'd0, 32'd0, 16'd0, 1,
                             uht_pkg::ST_NONE, 16'd0));
      foreach (directed[j]) send_request(directed[j]);
      drain_answers();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 61; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 61; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         while (requests < 24 + 46 * (phase + 1)) run_round();
         drain_answers();
      end

      $display("%0d requests, %0d answers checked over directed rows and random rounds",
               requests, answers);
      $display("idle mixes: none, sender 61%%, receiver 61%%, both 31%%");
      if (errors == 0 && answer_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d errors, %0d answers missing", errors, answer_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/uht_pkg.sv
hw/rtl/uniqueness_hash_table_top.sv
test/tb_top.sv
